// ===== rtl/core/lss_pkg.sv =====
// Shared types and constants for the search-capable LIFO stack.
package lss_pkg;

  localparam int unsigned DefStackDepth = 64;
  localparam int unsigned DefDataWidth  = 32;
  localparam int unsigned OperandWidth  = 32;
  localparam int unsigned StatusWidth   = 3;
  localparam int unsigned OpWidth       = 2;

  typedef enum logic [OpWidth-1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_SEARCH = 2'd2,
    OP_ALT    = 2'd3
  } op_e;

  typedef enum logic [StatusWidth-1:0] {
    ST_PUSHED    = 3'd0,
    ST_POPPED    = 3'd1,
    ST_UNDERFLOW = 3'd2,
    ST_OVERFLOW  = 3'd3,
    ST_SEARCHED  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE = 2'b01,
    FSM_SCAN = 2'b10
  } fsm_e;

endpackage

// ===== rtl/core/lss_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lss_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/lifo_stack_with_search.sv =====
// LIFO stack top level: push, pop and top-down membership search over a RAM.
//
//  port group   | direction | timing
//  -------------+-----------+--------------------------------------------------
//  command      | in        | start, operation_i, operand_value_i; taken when !busy
//  result       | out       | done_o strobe, status_o, found_o, depth_now_o; one cycle
//
//  Push and pop: result in the cycle after the command; a new command may follow at once.
//  Search: scans entries from the top down, one per RAM read, and stops at the first match
//  or after the bottom entry (at most STACK_DEPTH entries) through the single RAM read port.
//  busy is high while a search scans; no command is taken then.
//  Reset empties the stack at once; no clearing pass is needed.
//  Results cannot be held off by the receiver.
module lifo_stack_with_search
  import lss_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = DefStackDepth,
  parameter int unsigned DATA_WIDTH  = DefDataWidth
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [OpWidth-1:0]                 operation_i,
  input  logic signed [OperandWidth-1:0]     operand_value_i,
  output logic                               done_o,
  output logic [StatusWidth-1:0]             status_o,
  output logic                               found_o,
  output logic [$clog2(STACK_DEPTH+1)-1:0]   depth_now_o
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] FullCount = CW'(STACK_DEPTH);

  fsm_e             state_q, state_d;
  logic [CW-1:0]    count_q, count_d;
  logic [AW-1:0]    ptr_q, ptr_d;
  logic [DATA_WIDTH-1:0] key_q, key_d;
  logic             done_q, done_d;
  logic             found_q, found_d;
  status_e          status_q, status_d;

  logic [DATA_WIDTH-1:0] word;
  logic             accept;
  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;
  logic             hit;
  op_e              op;

  generate
    if (DATA_WIDTH <= OperandWidth) begin : g_trunc
      assign word = operand_value_i[DATA_WIDTH-1:0];
    end else begin : g_sext
      assign word = {{(DATA_WIDTH-OperandWidth){operand_value_i[OperandWidth-1]}},
                     operand_value_i};
    end
  endgenerate

  assign op     = op_e'(operation_i);
  assign busy   = (state_q != FSM_IDLE);
  assign accept = start && !busy;
  assign hit    = (ram_rdata == key_q);

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    ptr_d     = ptr_q;
    key_d     = key_q;
    done_d    = 1'b0;
    found_d   = 1'b0;
    status_d  = status_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = AW'(ptr_q - AW'(1));
    unique case (state_q)
      FSM_IDLE: begin
        ram_raddr = AW'(count_q - CW'(1));
        if (accept) begin
          done_d = 1'b1;
          case (op)
            OP_PUSH: begin
              if (count_q == FullCount) begin
                status_d = ST_OVERFLOW;
              end else begin
                ram_we   = 1'b1;
                count_d  = count_q + CW'(1);
                status_d = ST_PUSHED;
              end
            end
            OP_POP: begin
              if (count_q == '0) begin
                status_d = ST_UNDERFLOW;
              end else begin
                count_d  = count_q - CW'(1);
                status_d = ST_POPPED;
              end
            end
            default: begin
              status_d = ST_SEARCHED;
              if (count_q != '0) begin
                done_d  = 1'b0;
                ram_re  = 1'b1;
                ptr_d   = AW'(count_q - CW'(1));
                key_d   = word;
                state_d = FSM_SCAN;
              end
            end
          endcase
        end
      end
      FSM_SCAN: begin
        if (hit || ptr_q == '0) begin
          done_d  = 1'b1;
          found_d = hit;
          state_d = FSM_IDLE;
        end else begin
          ram_re = 1'b1;
          ptr_d  = ptr_q - AW'(1);
        end
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  lss_ram #(
    .Width(DATA_WIDTH),
    .Depth(STACK_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(count_q[AW-1:0]),
    .wdata_i(word),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= FSM_IDLE;
      count_q  <= '0;
      done_q   <= 1'b0;
      found_q  <= 1'b0;
      status_q <= ST_PUSHED;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      done_q   <= done_d;
      found_q  <= found_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    key_q <= key_d;
  end

  assign done_o      = done_q;
  assign status_o    = status_q;
  assign found_o     = found_q;
  assign depth_now_o = count_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while scanning");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCount)
    else $error("entry count beyond stack depth");

  a_scan_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FSM_SCAN && ptr_q == '0) |=> done_o)
    else $error("scan passed bottom without result");

  a_pushpop_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (op == OP_PUSH || op == OP_POP)) |=> (done_o && !busy))
    else $error("push or pop did not finish in one cycle");

  a_found_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_o |-> (done_o && status_o == ST_SEARCHED))
    else $error("found flag outside a search result");

endmodule
